@@ sv/multi_switch_debounce_lockout_defines.svh @@
// Assertion macros shared by the switch debouncer checker.
`ifndef MULTI_SWITCH_DEBOUNCE_LOCKOUT_DEFINES_SVH
`define MULTI_SWITCH_DEBOUNCE_LOCKOUT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MSDL_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MSDL_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/msdl_pkg.sv @@
// Shared constants and types for the multi-switch debouncer.
package msdl_pkg;

    // Switch count is fixed by the 15-bit pin and mask fields.
    localparam int LANE_COUNT  = 15;
    localparam int COUNT_WIDTH = 16;

    // Stream payload widths, padded to whole bytes.
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 64;
    localparam int RES_W    = 4 * LANE_COUNT;

    // APB register map
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam logic [1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [1:0] REG_LOCKOUT  = 2'd1;
    localparam logic [1:0] REG_TYPES    = 2'd2;

    localparam int SET_W   = 16;
    localparam int TYPES_W = 2 * LANE_COUNT;

    // Switch type codes
    localparam logic [1:0] TYPE_DISABLED = 2'd0;
    localparam logic [1:0] TYPE_NO       = 2'd1;
    localparam logic [1:0] TYPE_NC       = 2'd2;

    // Per-lane status after one tick
    typedef struct packed {
        logic event_bit;
        logic active_bit;
        logic level_bit;
        logic ready_bit;
    } lane_out_t;

    // Result item, event mask in the lowest bits
    typedef struct packed {
        logic [LANE_COUNT-1:0] ready_mask;
        logic [LANE_COUNT-1:0] level_mask;
        logic [LANE_COUNT-1:0] active_mask;
        logic [LANE_COUNT-1:0] event_mask;
    } result_t;

endpackage

@@ sv/msdl_lane.sv @@
// One switch lane: lockout countdown, settle counter and stored level.
module msdl_lane #(
    parameter int COUNT_WIDTH = msdl_pkg::COUNT_WIDTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step_en,
    input  logic                   pin,
    input  logic [1:0]             sw_type,
    input  logic [COUNT_WIDTH-1:0] debounce_cnt,
    input  logic [COUNT_WIDTH-1:0] lockout_cnt,
    output msdl_pkg::lane_out_t    lane_out
);

    logic                   level_reg, level_next;
    logic                   ready_reg, ready_next;
    logic [COUNT_WIDTH-1:0] settle_reg, settle_next;
    logic [COUNT_WIDTH-1:0] hold_reg, hold_next;
    logic [COUNT_WIDTH-1:0] hold_dec;
    logic [COUNT_WIDTH-1:0] settle_inc;
    logic                   skip;
    logic                   qualify;

    // Tick update for this switch
    always_comb begin
        level_next  = level_reg;
        ready_next  = ready_reg;
        settle_next = settle_reg;
        hold_next   = hold_reg;
        hold_dec    = hold_reg - COUNT_WIDTH'(1);
        settle_inc  = settle_reg + COUNT_WIDTH'(1);
        skip        = 1'b0;
        qualify     = 1'b0;
        if (sw_type != msdl_pkg::TYPE_DISABLED) begin
            // lockout countdown; debounce resumes on the expiry tick
            if (hold_reg != '0) begin
                hold_next = hold_dec;
                skip      = (hold_dec != '0);
            end
            if (!skip) begin
                if (pin == level_reg && ready_reg) begin
                    settle_next = '0;
                end else if (settle_inc == debounce_cnt) begin
                    qualify     = 1'b1;
                    level_next  = pin;
                    settle_next = '0;
                    ready_next  = 1'b1;
                    hold_next   = lockout_cnt;
                end else begin
                    settle_next = settle_inc;
                end
            end
        end
    end

    // State registers, advanced on each accepted tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg  <= 1'b0;
            ready_reg  <= 1'b0;
            settle_reg <= '0;
            hold_reg   <= '0;
        end else if (step_en) begin
            level_reg  <= level_next;
            ready_reg  <= ready_next;
            settle_reg <= settle_next;
            hold_reg   <= hold_next;
        end
    end

    // Status from the post-tick state
    always_comb begin
        lane_out.event_bit  = qualify;
        lane_out.level_bit  = level_next;
        lane_out.ready_bit  = ready_next;
        lane_out.active_bit = ready_next &&
            ((sw_type == msdl_pkg::TYPE_NO && !level_next) ||
             (sw_type == msdl_pkg::TYPE_NC && level_next));
    end

endmodule

@@ sv/msdl_merge.sv @@
// Merges lane status into result masks and holds them in a two-entry skid.
module msdl_merge (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  msdl_pkg::lane_out_t [msdl_pkg::LANE_COUNT-1:0] lanes,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output msdl_pkg::result_t                      out_result
);

    msdl_pkg::result_t merged;
    msdl_pkg::result_t out_data_reg, out_data_next;
    msdl_pkg::result_t skid_data_reg, skid_data_next;
    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    logic              accept;
    logic              take;

    // Gather one bit per lane into each mask
    always_comb begin
        for (int i = 0; i < msdl_pkg::LANE_COUNT; i++) begin
            merged.event_mask[i]  = lanes[i].event_bit;
            merged.active_mask[i] = lanes[i].active_bit;
            merged.level_mask[i]  = lanes[i].level_bit;
            merged.ready_mask[i]  = lanes[i].ready_bit;
        end
    end

    assign in_ready = !skid_valid_reg;
    assign accept   = in_valid && in_ready;
    assign take     = out_valid_reg && out_ready;

    // Output register with skid entry behind it
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (accept) begin
            if (!out_valid_reg || take) begin
                out_valid_next = 1'b1;
                out_data_next  = merged;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = merged;
            end
        end else if (take) begin
            if (skid_valid_reg) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_data_reg;

endmodule

@@ sv/multi_switch_debounce_lockout.sv @@
// Multi-switch debouncer with lockout: takes one pin sample per cycle, one
// result per sample. Each of the 15 switches has its own lane (lockout and
// settle counters of COUNT_WIDTH bits), all updated in the same cycle, so a
// new sample is accepted every cycle while the output side keeps up; the
// result is registered into a two-entry output skid, and input ready drops
// only when both entries hold results. A changed level qualifies after
// debounce_ticks samples (0 means 2^COUNT_WIDTH), then the switch ignores its
// pin for lockout_ticks - 1 samples and is debounced again on the sample the
// lockout expires. Registers at byte addresses 0 (debounce_ticks), 4
// (lockout_ticks), 8 (switch_types, two bits per switch: 0 disabled, 1 normally
// open, 2 normally closed); write only while idle. No clearing pass after reset.
module multi_switch_debounce_lockout #(
    parameter int COUNT_WIDTH = msdl_pkg::COUNT_WIDTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [msdl_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [msdl_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [msdl_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    // pin samples
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [msdl_pkg::S_DATA_W-1:0]   s_tdata,  // [14:0] pin_levels
    // results
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [14:0] event_mask, [29:15] active_mask, [44:30] level_mask, [59:45] ready_mask
    output logic [msdl_pkg::M_DATA_W-1:0]   m_tdata
);

    logic [msdl_pkg::SET_W-1:0]   debounce_reg;
    logic [msdl_pkg::SET_W-1:0]   lockout_reg;
    logic [msdl_pkg::TYPES_W-1:0] types_reg;
    logic [1:0]                   reg_idx;
    logic                         cfg_wr;
    logic                         step_en;
    logic [COUNT_WIDTH-1:0]       debounce_cnt;
    logic [COUNT_WIDTH-1:0]       lockout_cnt;
    msdl_pkg::lane_out_t [msdl_pkg::LANE_COUNT-1:0] lanes;
    msdl_pkg::result_t            result;

    // APB register file
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= msdl_pkg::SET_W'(5);
            lockout_reg  <= msdl_pkg::SET_W'(250);
            types_reg    <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                msdl_pkg::REG_DEBOUNCE: debounce_reg <= pwdata[msdl_pkg::SET_W-1:0];
                msdl_pkg::REG_LOCKOUT:  lockout_reg  <= pwdata[msdl_pkg::SET_W-1:0];
                msdl_pkg::REG_TYPES:    types_reg    <= pwdata[msdl_pkg::TYPES_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            msdl_pkg::REG_DEBOUNCE: prdata = msdl_pkg::CFG_DATA_W'(debounce_reg);
            msdl_pkg::REG_LOCKOUT:  prdata = msdl_pkg::CFG_DATA_W'(lockout_reg);
            msdl_pkg::REG_TYPES:    prdata = msdl_pkg::CFG_DATA_W'(types_reg);
            default:                prdata = '0;
        endcase
    end

    // Settings taken modulo the counter width
    assign debounce_cnt = COUNT_WIDTH'(debounce_reg);
    assign lockout_cnt  = COUNT_WIDTH'(lockout_reg);
    assign step_en      = s_tvalid && s_tready;

    // One lane per switch
    for (genvar g = 0; g < msdl_pkg::LANE_COUNT; g++) begin : g_lane
        msdl_lane #(
            .COUNT_WIDTH(COUNT_WIDTH)
        ) u_lane (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .step_en     (step_en),
            .pin         (s_tdata[g]),
            .sw_type     (types_reg[2*g +: 2]),
            .debounce_cnt(debounce_cnt),
            .lockout_cnt (lockout_cnt),
            .lane_out    (lanes[g])
        );
    end

    // Mask merge and output buffering
    msdl_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .lanes     (lanes),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_result(result)
    );

    assign m_tdata = msdl_pkg::M_DATA_W'(result);

endmodule

@@ sv/msdl_checker.sv @@
// Port-level checks for the multi-switch debouncer, bound to the top level.
`include "multi_switch_debounce_lockout_defines.svh"

module msdl_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [msdl_pkg::M_DATA_W-1:0] m_tdata
);

    // A stalled result holds its payload
    `MSDL_ASSERT_NXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // After every accepted sample a result is offered the next cycle
    `MSDL_ASSERT_NXT(a_result, aclk, aresetn, s_tvalid && s_tready, m_tvalid, "accepted sample gave no result")

    // Active switches are always qualified ones
    `MSDL_ASSERT_IMP(a_active, aclk, aresetn, m_tvalid, (m_tdata[29:15] & ~m_tdata[59:45]) == 15'd0, "active bit on unqualified switch")

    // An event leaves the switch qualified
    `MSDL_ASSERT_IMP(a_event, aclk, aresetn, m_tvalid, (m_tdata[14:0] & ~m_tdata[59:45]) == 15'd0, "event bit on unqualified switch")

endmodule

bind multi_switch_debounce_lockout msdl_checker u_msdl_checker (.*);

@@ sim/tb.sv @@
// Self-checking testbench for the multi-switch debouncer with lockout.

// Tracks per-switch debounce state and holds the status words still owed by the block
class switch_status_checker;
    logic [msdl_pkg::COUNT_WIDTH-1:0] settle_limit;
    logic [msdl_pkg::COUNT_WIDTH-1:0] lockout_load;
    logic [msdl_pkg::TYPES_W-1:0]     sw_types;
    logic [msdl_pkg::LANE_COUNT-1:0]  stored_level;
    logic [msdl_pkg::LANE_COUNT-1:0]  qualified;
    logic [msdl_pkg::COUNT_WIDTH-1:0] settle_cnt[msdl_pkg::LANE_COUNT];
    logic [msdl_pkg::COUNT_WIDTH-1:0] lockout_cnt[msdl_pkg::LANE_COUNT];
    msdl_pkg::result_t                expected_status[$];
    int                               errors;

    function new();
        settle_limit = 16'd5;
        lockout_load = 16'd250;
        sw_types     = '0;
        stored_level = '0;
        qualified    = '0;
        for (int i = 0; i < msdl_pkg::LANE_COUNT; i++) begin
            settle_cnt[i]  = '0;
            lockout_cnt[i] = '0;
        end
        errors = 0;
    endfunction

    // Mirror of a register write; unmapped indexes are dropped
    function void set_reg(logic [1:0] idx, logic [msdl_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            msdl_pkg::REG_DEBOUNCE: settle_limit = val[msdl_pkg::SET_W-1:0];
            msdl_pkg::REG_LOCKOUT:  lockout_load = val[msdl_pkg::SET_W-1:0];
            msdl_pkg::REG_TYPES:    sw_types     = val[msdl_pkg::TYPES_W-1:0];
            default: ;
        endcase
    endfunction

    // Advance every switch by one tick and queue the resulting status word
    function void note_tick(logic [msdl_pkg::LANE_COUNT-1:0] pins);
        msdl_pkg::result_t st;
        logic [1:0]        kind;
        logic              skip;
        st = '0;
        for (int i = 0; i < msdl_pkg::LANE_COUNT; i++) begin
            kind = sw_types[2*i +: 2];
            if (kind != msdl_pkg::TYPE_DISABLED) begin
                skip = 1'b0;
                // lockout expiry lets the pin be debounced in the same tick
                if (lockout_cnt[i] != 0) begin
                    lockout_cnt[i] = lockout_cnt[i] - msdl_pkg::COUNT_WIDTH'(1);
                    if (lockout_cnt[i] != 0)
                        skip = 1'b1;
                end
                if (!skip) begin
                    if (pins[i] == stored_level[i] && qualified[i]) begin
                        settle_cnt[i] = '0;
                    end else begin
                        settle_cnt[i] = settle_cnt[i] + msdl_pkg::COUNT_WIDTH'(1);
                        if (settle_cnt[i] == settle_limit) begin
                            stored_level[i]   = pins[i];
                            settle_cnt[i]     = '0;
                            qualified[i]      = 1'b1;
                            lockout_cnt[i]    = lockout_load;
                            st.event_mask[i]  = 1'b1;
                        end
                    end
                end
            end
            if (qualified[i]) begin
                st.ready_mask[i] = 1'b1;
                if ((kind == msdl_pkg::TYPE_NO && !stored_level[i]) ||
                    (kind == msdl_pkg::TYPE_NC && stored_level[i]))
                    st.active_mask[i] = 1'b1;
            end
        end
        st.level_mask = stored_level;
        expected_status.push_back(st);
    endfunction

    function int pending();
        return expected_status.size();
    endfunction

    function void flag(string what, logic [msdl_pkg::LANE_COUNT-1:0] want,
                       logic [msdl_pkg::LANE_COUNT-1:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= 10)
                $display("mismatch %s: expected %h got %h", what, want, got);
        end
    endfunction

    // Compare one received status word with the oldest one owed
    function void check_status(logic [msdl_pkg::M_DATA_W-1:0] data);
        msdl_pkg::result_t got;
        msdl_pkg::result_t want;
        got = data[msdl_pkg::RES_W-1:0];
        if (expected_status.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected status word %h", data);
        end else begin
            want = expected_status.pop_front();
            flag("event_mask", want.event_mask, got.event_mask);
            flag("active_mask", want.active_mask, got.active_mask);
            flag("level_mask", want.level_mask, got.level_mask);
            flag("ready_mask", want.ready_mask, got.ready_mask);
        end
    endfunction
endclass

module tb;
    localparam logic [1:0] TYPE_SPARE = 2'd3;
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 60;

    logic                            aclk    = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            psel    = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite  = 1'b0;
    logic [msdl_pkg::CFG_ADDR_W-1:0] paddr   = '0;
    logic [msdl_pkg::CFG_DATA_W-1:0] pwdata  = '0;
    logic [msdl_pkg::CFG_DATA_W-1:0] prdata;
    logic                            pready;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [msdl_pkg::S_DATA_W-1:0]   s_tdata  = '0;   // [14:0] pin_levels
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    // [14:0] event_mask, [29:15] active_mask, [44:30] level_mask, [59:45] ready_mask
    logic [msdl_pkg::M_DATA_W-1:0]   m_tdata;

    switch_status_checker chk = new();
    int ticks_sent  = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit hold_req    = 1'b0;

    multi_switch_debounce_lockout u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 aclk = ~aclk;

    // APB write: setup and access phases, then the bus is released
    task automatic cfg_write(input logic [1:0] idx,
                             input logic [msdl_pkg::CFG_DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        chk.set_reg(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // Stop offering ticks and wait until every status word has come back
    task automatic settle_idle();
        s_tvalid <= 1'b0;
        while (chk.pending() != 0)
            @(posedge aclk);
    endtask

    // One pin-sample transfer, with random sender gaps ahead of it
    task automatic send_tick(input logic [msdl_pkg::LANE_COUNT-1:0] pins);
        if (ticks_sent < 370) begin
            tx_idle_pct = 28;
            rx_idle_pct = 68;
        end else if (ticks_sent < 740) begin
            tx_idle_pct = 68;
            rx_idle_pct = 28;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, pins};
        do @(posedge aclk); while (!s_tready);
        chk.note_tick(pins);
        ticks_sent++;
        if (ticks_sent == 520)
            hold_req = 1'b1;
    endtask

    // Mostly slowly drifting pin levels so switches qualify, some pure noise
    task automatic run_phase(input logic [msdl_pkg::SET_W-1:0] deb,
                             input logic [msdl_pkg::SET_W-1:0] lock,
                             input logic [msdl_pkg::TYPES_W-1:0] types, input int n);
        logic [msdl_pkg::LANE_COUNT-1:0] drift;
        drift = msdl_pkg::LANE_COUNT'($urandom);
        settle_idle();
        cfg_write(msdl_pkg::REG_DEBOUNCE, {16'd0, deb});
        cfg_write(msdl_pkg::REG_LOCKOUT, {16'd0, lock});
        cfg_write(msdl_pkg::REG_TYPES, {2'b00, types});
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(99) < 15) begin
                send_tick(msdl_pkg::LANE_COUNT'($urandom));
            end else begin
                drift = drift ^ msdl_pkg::LANE_COUNT'($urandom & $urandom & $urandom);
                send_tick(drift);
            end
        end
    endtask

    // Result side: random stalls plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                chk.check_status(m_tdata);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Main sequence
    initial begin
        logic [msdl_pkg::TYPES_W-1:0]    mix;
        logic [msdl_pkg::LANE_COUNT-1:0] edges_a[7];
        logic [msdl_pkg::LANE_COUNT-1:0] edges_b[9];
        logic [1:0]                      codes[4];
        codes   = '{msdl_pkg::TYPE_DISABLED, msdl_pkg::TYPE_NO, msdl_pkg::TYPE_NC, TYPE_SPARE};
        edges_a = '{15'h0000, 15'h7FFF, 15'h7FFF, 15'h0000, 15'h5555, 15'h2AAA, 15'h7FFF};
        edges_b = '{15'h0000, 15'h0000, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF,
                    15'h0000, 15'h0000, 15'h0000};
        for (int i = 0; i < msdl_pkg::LANE_COUNT; i++)
            mix[2*i +: 2] = codes[i % 4];

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: every switch disabled
        send_tick('1);
        send_tick('0);

        // one-tick debounce, no lockout, every type present
        settle_idle();
        cfg_write(msdl_pkg::REG_TYPES, {2'b00, mix});
        cfg_write(msdl_pkg::REG_DEBOUNCE, 32'd1);
        cfg_write(msdl_pkg::REG_LOCKOUT, 32'd0);
        cfg_write(REG_UNUSED, 32'hFFFF_FFFF);
        foreach (edges_a[k])
            send_tick(edges_a[k]);

        // short lockout: pin is debounced again on the tick it expires
        settle_idle();
        cfg_write(msdl_pkg::REG_DEBOUNCE, 32'd2);
        cfg_write(msdl_pkg::REG_LOCKOUT, 32'd2);
        foreach (edges_b[k])
            send_tick(edges_b[k]);

        // type change keeps stored state; all switches on the spare code
        settle_idle();
        cfg_write(msdl_pkg::REG_TYPES, 32'h3FFF_FFFF);
        send_tick(15'h7FFF);
        send_tick(15'h0000);
        send_tick(15'h7FFF);

        run_phase(16'd1, 16'd0, msdl_pkg::TYPES_W'($urandom), 150);
        run_phase(16'd2, 16'd3, msdl_pkg::TYPES_W'($urandom), 150);
        run_phase(16'd3, 16'd1, msdl_pkg::TYPES_W'($urandom), 150);
        run_phase(16'd4, 16'd6, msdl_pkg::TYPES_W'($urandom), 150);
        run_phase(16'd1, 16'd2, 30'h2AAA_AAAA, 100);
        run_phase(16'd2, 16'd0, msdl_pkg::TYPES_W'($urandom), 150);
        run_phase(16'd5, 16'd20, msdl_pkg::TYPES_W'($urandom), 120);
        // extreme settings last: they leave counters far from small limits
        run_phase(16'd1, 16'hFFFF, msdl_pkg::TYPES_W'($urandom), 40);
        run_phase(16'hFFFF, 16'd0, msdl_pkg::TYPES_W'($urandom), 40);
        run_phase(16'd0, 16'd7, 30'd0, 30);

        settle_idle();
        repeat (4) @(posedge aclk);
        if (chk.errors == 0 && chk.pending() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #400000;
        $display("tb NOT OK");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+sv
sv/msdl_pkg.sv
sv/msdl_lane.sv
sv/msdl_merge.sv
sv/multi_switch_debounce_lockout.sv
sv/msdl_checker.sv
sim/tb.sv
